// ===== rtl/lav_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Look-at view matrix: shared package
// Fixed-point formats, internal widths, pipeline depths and word types used
// by the view matrix pipeline and its channel interfaces.
// ---------------------------------------------------------------------------
package lav_pkg;

	// Data format: signed two's complement with FRAC_BITS fraction bits.
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	// Normalizer widths. Magnitudes enter with up to MAG_W bits and are
	// scaled so that the largest one has its top bit at NRM_W - 1.
	localparam int MAG_W  = DATA_WIDTH + 2;
	localparam int LZ_W   = $clog2(MAG_W);
	localparam int NRM_W  = 31;
	localparam int SQ_W   = 2 * NRM_W;
	localparam int SUM_W  = SQ_W + 2;
	localparam int ROOT_W = SUM_W / 2;
	localparam int QUO_W  = FRAC_BITS + 1;
	localparam int NUM_W  = NRM_W + FRAC_BITS + 1;

	// Datapath widths after normalization.
	localparam int UNIT_W = FRAC_BITS + 2;
	localparam int PRD_W  = 2 * UNIT_W;
	localparam int CRS_W  = PRD_W + 1;
	localparam int ROW_W  = UNIT_W + 2;
	localparam int TPR_W  = ROW_W + DATA_WIDTH;
	localparam int TSM_W  = TPR_W + 2;

	// Normalizer depth: scale, square, sum, one stage per root bit,
	// dividend setup, one stage per quotient bit, output register.
	localparam int NORM_LAT = 5 + ROOT_W + QUO_W;

	typedef logic signed [DATA_WIDTH-1:0] fx_t;
	typedef logic signed [UNIT_W-1:0]     unit_t;
	typedef logic        [MAG_W-1:0]      mag_t;

	localparam fx_t ONE_FX = fx_t'(64'd1 << FRAC_BITS);

	// Row codes on the result channel.
	localparam logic [1:0] ROW_SIDE  = 2'd0;
	localparam logic [1:0] LAST_ROW  = 2'd3;

	// One finished matrix: rows 0 to 2 with four entries each.
	typedef struct packed {
		logic                              deg;
		logic [2:0][3:0][DATA_WIDTH-1:0]   ent;
	} mat_t;

endpackage

// ===== rtl/lav_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Look-at view matrix: channel interfaces
// The point channel carries eye, target and up; the row channel carries one
// matrix row per word.
// ---------------------------------------------------------------------------
interface lav_pts_if;
	logic          valid;
	logic          ready;
	lav_pkg::fx_t  eye_x;
	lav_pkg::fx_t  eye_y;
	lav_pkg::fx_t  eye_z;
	lav_pkg::fx_t  target_x;
	lav_pkg::fx_t  target_y;
	lav_pkg::fx_t  target_z;
	lav_pkg::fx_t  up_x;
	lav_pkg::fx_t  up_y;
	lav_pkg::fx_t  up_z;

	modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
		up_x, up_y, up_z, input ready);
	modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
		up_x, up_y, up_z, output ready);
endinterface

interface lav_rows_if;
	logic          valid;
	logic          ready;
	logic [1:0]    row_index;
	lav_pkg::fx_t  entry_0;
	lav_pkg::fx_t  entry_1;
	lav_pkg::fx_t  entry_2;
	lav_pkg::fx_t  entry_3;
	logic          degenerate;
	logic          last_row;

	modport source (output valid, row_index, entry_0, entry_1, entry_2, entry_3,
		degenerate, last_row, input ready);
	modport sink (input valid, row_index, entry_0, entry_1, entry_2, entry_3,
		degenerate, last_row, output ready);
endinterface

// ===== rtl/look_at_view_matrix_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Look-at view matrix unit
// Builds the 4x4 camera view matrix from eye, target and up points and sends
// it out one row per word.
// ---------------------------------------------------------------------------
// The point channel takes a word in any cycle in which the pipeline moves;
// words flow through a fully pipelined datapath (two normalizers in parallel
// for forward and up, then the side normalizer, two cross products and the
// translation dot products). Each word yields four row words on the row
// channel, rows 0 to 3 in order, so in steady flow the row channel sets the
// rate at which point words are taken. A finished matrix is held in an output
// register while the next ones advance; the whole pipeline stalls together
// only when that register is still busy and another matrix is ready behind it.
// ---------------------------------------------------------------------------
module look_at_view_matrix_unit (
	input  logic        clk,
	input  logic        arst_n,
	lav_pts_if.sink     pts,
	lav_rows_if.source  rows
);
	import lav_pkg::*;

	logic en;
	logic take;

	// Input stage signals.
	fx_t                      e_in [3];
	fx_t                      t_in [3];
	fx_t                      u_in [3];
	logic [2:0]               fneg_n;
	logic [2:0]               uneg_n;
	mag_t                     fmag_n [3];
	mag_t                     umag_n [3];

	logic                     v_s1;
	logic [2:0][DATA_WIDTH-1:0] eye_s1;
	logic [2:0]               fneg_s1;
	logic [2:0]               uneg_s1;
	mag_t                     fmag_s1 [3];
	mag_t                     umag_s1 [3];

	unit_t                    f_n [3];
	unit_t                    u_n [3];
	logic                     f_nz;
	logic                     u_nz;

	logic [NORM_LAT-1:0]      a_v_q;
	logic [2:0][DATA_WIDTH-1:0] a_eye_q [NORM_LAT];

	logic                     v_s2;
	logic signed [PRD_W-1:0]  cp_s2 [6];
	logic [2:0][DATA_WIDTH-1:0] eye_s2;
	logic [2:0][UNIT_W-1:0]   f_s2;
	logic                     nzfu_s2;

	logic signed [CRS_W-1:0]  sr_n [3];
	logic                     v_s3;
	logic [2:0]               sneg_s3;
	mag_t                     smag_s3 [3];
	logic [2:0][DATA_WIDTH-1:0] eye_s3;
	logic [2:0][UNIT_W-1:0]   f_s3;
	logic                     nzfu_s3;

	unit_t                    s_n [3];
	logic                     s_nz;

	logic [NORM_LAT-1:0]      b_v_q;
	logic [2:0][DATA_WIDTH-1:0] b_eye_q [NORM_LAT];
	logic [2:0][UNIT_W-1:0]   b_f_q   [NORM_LAT];
	logic [NORM_LAT-1:0]      b_nzfu_q;

	logic                     v_s4;
	logic signed [PRD_W-1:0]  x2_s4 [6];
	logic [2:0][DATA_WIDTH-1:0] eye_s4;
	unit_t                    f_s4 [3];
	unit_t                    ns_s4 [3];
	logic                     ok_s4;

	logic signed [CRS_W-1:0]  uw_n [3];
	logic [CRS_W-1:0]         uwa_n [3];
	logic [CRS_W-1:0]         uwr_n [3];
	logic signed [ROW_W-1:0]  rw_n [3][3];

	logic                     v_s5;
	logic signed [ROW_W-1:0]  rw_s5 [3][3];
	logic [2:0][DATA_WIDTH-1:0] eye_s5;
	logic                     ok_s5;

	logic                     v_s6;
	logic signed [TPR_W-1:0]  tp_s6 [3][3];
	logic signed [ROW_W-1:0]  rw_s6 [3][3];
	logic                     ok_s6;

	logic signed [TSM_W-1:0]  ts_n [3];
	logic                     v_s7;
	logic [2:0]               tr_neg_s7;
	logic [TSM_W-1:0]         tr_mag_s7 [3];
	logic signed [ROW_W-1:0]  rw_s7 [3][3];
	logic                     ok_s7;

	logic [TSM_W-1:0]         rnd_n [3];
	logic [TSM_W-1:0]         trs_n [3];
	mat_t                     mat_n;

	logic                     v_s8;
	mat_t                     mat_s8;

	logic                     full_q;
	logic [1:0]               cnt_q;
	mat_t                     mat_q;

	localparam logic [TSM_W-1:0] HALF_LSB = TSM_W'(1) << (FRAC_BITS - 1);
	localparam logic [TSM_W-1:0] SAT_LIM  = TSM_W'(1) << (DATA_WIDTH - 1);

	// Pipeline advances unless a finished matrix has nowhere to go.
	assign take      = !full_q || (rows.ready && (cnt_q == LAST_ROW));
	assign en        = !v_s8 || take;
	assign pts.ready = en;

	// Forward difference and up magnitude, as sign plus magnitude.
	always_comb begin
		logic signed [DATA_WIDTH:0] d;
		logic signed [DATA_WIDTH:0] ue;
		e_in[0] = pts.eye_x;    e_in[1] = pts.eye_y;    e_in[2] = pts.eye_z;
		t_in[0] = pts.target_x; t_in[1] = pts.target_y; t_in[2] = pts.target_z;
		u_in[0] = pts.up_x;     u_in[1] = pts.up_y;     u_in[2] = pts.up_z;
		for (int i = 0; i < 3; i++) begin
			d  = (DATA_WIDTH + 1)'(t_in[i]) - (DATA_WIDTH + 1)'(e_in[i]);
			ue = (DATA_WIDTH + 1)'(u_in[i]);
			fneg_n[i] = d[DATA_WIDTH];
			uneg_n[i] = ue[DATA_WIDTH];
			fmag_n[i] = MAG_W'($unsigned(d[DATA_WIDTH] ? -d : d));
			umag_n[i] = MAG_W'($unsigned(ue[DATA_WIDTH] ? -ue : ue));
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			a_v_q    <= '0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			b_v_q    <= '0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			v_s7     <= 1'b0;
			v_s8     <= 1'b0;
		end else if (en) begin
			v_s1  <= pts.valid;
			a_v_q <= {a_v_q[NORM_LAT-2:0], v_s1};
			v_s2  <= a_v_q[NORM_LAT-1];
			v_s3  <= v_s2;
			b_v_q <= {b_v_q[NORM_LAT-2:0], v_s3};
			v_s4  <= b_v_q[NORM_LAT-1];
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				eye_s1[i] <= e_in[i];
			end
			fneg_s1 <= fneg_n;
			uneg_s1 <= uneg_n;
			fmag_s1 <= fmag_n;
			umag_s1 <= umag_n;
		end
	end

	// Forward and up normalizers run side by side.
	lav_norm u_norm_f (
		.clk  (clk),
		.en   (en),
		.neg  (fneg_s1),
		.mag  (fmag_s1),
		.unit (f_n),
		.nz   (f_nz)
	);

	lav_norm u_norm_u (
		.clk  (clk),
		.en   (en),
		.neg  (uneg_s1),
		.mag  (umag_s1),
		.unit (u_n),
		.nz   (u_nz)
	);

	// Eye rides alongside the first normalizers.
	always_ff @(posedge clk) begin
		if (en) begin
			a_eye_q[0] <= eye_s1;
			for (int k = 1; k < NORM_LAT; k++) begin
				a_eye_q[k] <= a_eye_q[k-1];
			end
		end
	end

	// Side vector f x up: products, then differences.
	always_comb begin
		sr_n[0] = CRS_W'(cp_s2[0]) - CRS_W'(cp_s2[1]);
		sr_n[1] = CRS_W'(cp_s2[2]) - CRS_W'(cp_s2[3]);
		sr_n[2] = CRS_W'(cp_s2[4]) - CRS_W'(cp_s2[5]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cp_s2[0] <= f_n[1] * u_n[2];
			cp_s2[1] <= f_n[2] * u_n[1];
			cp_s2[2] <= f_n[2] * u_n[0];
			cp_s2[3] <= f_n[0] * u_n[2];
			cp_s2[4] <= f_n[0] * u_n[1];
			cp_s2[5] <= f_n[1] * u_n[0];
			eye_s2   <= a_eye_q[NORM_LAT-1];
			for (int i = 0; i < 3; i++) begin
				f_s2[i] <= f_n[i];
			end
			nzfu_s2  <= f_nz & u_nz;

			for (int i = 0; i < 3; i++) begin
				sneg_s3[i] <= sr_n[i][CRS_W-1];
				smag_s3[i] <= MAG_W'($unsigned(sr_n[i][CRS_W-1] ? -sr_n[i] : sr_n[i]));
			end
			eye_s3  <= eye_s2;
			f_s3    <= f_s2;
			nzfu_s3 <= nzfu_s2;
		end
	end

	// Side normalizer.
	lav_norm u_norm_s (
		.clk  (clk),
		.en   (en),
		.neg  (sneg_s3),
		.mag  (smag_s3),
		.unit (s_n),
		.nz   (s_nz)
	);

	// Eye, forward and flags ride alongside the side normalizer.
	always_ff @(posedge clk) begin
		if (en) begin
			b_eye_q[0] <= eye_s3;
			b_f_q[0]   <= f_s3;
			for (int k = 1; k < NORM_LAT; k++) begin
				b_eye_q[k] <= b_eye_q[k-1];
				b_f_q[k]   <= b_f_q[k-1];
			end
			b_nzfu_q <= {b_nzfu_q[NORM_LAT-2:0], nzfu_s3};
		end
	end

	// True up s x f: products.
	always_ff @(posedge clk) begin
		unit_t fb [3];
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				fb[i] = unit_t'(b_f_q[NORM_LAT-1][i]);
			end
			x2_s4[0] <= s_n[1] * fb[2];
			x2_s4[1] <= s_n[2] * fb[1];
			x2_s4[2] <= s_n[2] * fb[0];
			x2_s4[3] <= s_n[0] * fb[2];
			x2_s4[4] <= s_n[0] * fb[1];
			x2_s4[5] <= s_n[1] * fb[0];
			eye_s4 <= b_eye_q[NORM_LAT-1];
			f_s4   <= fb;
			ns_s4  <= s_n;
			ok_s4  <= s_nz & b_nzfu_q[NORM_LAT-1];
		end
	end

	// True up differences, rounding, and the three rows with the zero mask.
	always_comb begin
		uw_n[0] = CRS_W'(x2_s4[0]) - CRS_W'(x2_s4[1]);
		uw_n[1] = CRS_W'(x2_s4[2]) - CRS_W'(x2_s4[3]);
		uw_n[2] = CRS_W'(x2_s4[4]) - CRS_W'(x2_s4[5]);
		for (int i = 0; i < 3; i++) begin
			uwa_n[i] = $unsigned(uw_n[i][CRS_W-1] ? -uw_n[i] : uw_n[i]);
			uwr_n[i] = (uwa_n[i] + (CRS_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
			if (!ok_s4) begin
				rw_n[0][i] = '0;
				rw_n[1][i] = '0;
				rw_n[2][i] = '0;
			end else begin
				rw_n[0][i] = ROW_W'(ns_s4[i]);
				rw_n[1][i] = uw_n[i][CRS_W-1] ? -$signed(ROW_W'(uwr_n[i]))
					: $signed(ROW_W'(uwr_n[i]));
				rw_n[2][i] = -ROW_W'(f_s4[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rw_s5  <= rw_n;
			eye_s5 <= eye_s4;
			ok_s5  <= ok_s4;
		end
	end

	// Translation: row times eye products.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					tp_s6[r][c] <= rw_s5[r][c] * $signed(eye_s5[c]);
				end
			end
			rw_s6 <= rw_s5;
			ok_s6 <= ok_s5;
		end
	end

	// Translation: dot product, taken against -eye as sign plus magnitude.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			ts_n[r] = TSM_W'(tp_s6[r][0]) + TSM_W'(tp_s6[r][1]) + TSM_W'(tp_s6[r][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				tr_neg_s7[r] <= (ts_n[r] > 0);
				tr_mag_s7[r] <= $unsigned(ts_n[r][TSM_W-1] ? -ts_n[r] : ts_n[r]);
			end
			rw_s7 <= rw_s6;
			ok_s7 <= ok_s6;
		end
	end

	// Round the translation, saturate, and assemble the matrix.
	always_comb begin
		mat_n.deg = !ok_s7;
		for (int r = 0; r < 3; r++) begin
			rnd_n[r] = (tr_mag_s7[r] + HALF_LSB) >> FRAC_BITS;
			if (tr_neg_s7[r]) begin
				trs_n[r] = (rnd_n[r] > SAT_LIM) ? -SAT_LIM : -rnd_n[r];
			end else begin
				trs_n[r] = (rnd_n[r] > SAT_LIM - 1'b1) ? SAT_LIM - 1'b1 : rnd_n[r];
			end
			for (int c = 0; c < 3; c++) begin
				mat_n.ent[r][c] = DATA_WIDTH'(rw_s7[r][c]);
			end
			mat_n.ent[r][3] = trs_n[r][DATA_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mat_s8 <= mat_n;
		end
	end

	// Output register: holds one matrix while its four rows go out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			cnt_q  <= ROW_SIDE;
		end else if (v_s8 && take) begin
			full_q <= 1'b1;
			cnt_q  <= ROW_SIDE;
		end else if (full_q && rows.ready) begin
			if (cnt_q == LAST_ROW) begin
				full_q <= 1'b0;
			end
			cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s8 && take) begin
			mat_q <= mat_s8;
		end
	end

	// Row select onto the result channel; row 3 is constant.
	always_comb begin
		rows.valid      = full_q;
		rows.row_index  = cnt_q;
		rows.degenerate = mat_q.deg;
		rows.last_row   = (cnt_q == LAST_ROW);
		if (cnt_q == LAST_ROW) begin
			rows.entry_0 = '0;
			rows.entry_1 = '0;
			rows.entry_2 = '0;
			rows.entry_3 = ONE_FX;
		end else begin
			rows.entry_0 = fx_t'(mat_q.ent[cnt_q][0]);
			rows.entry_1 = fx_t'(mat_q.ent[cnt_q][1]);
			rows.entry_2 = fx_t'(mat_q.ent[cnt_q][2]);
			rows.entry_3 = fx_t'(mat_q.ent[cnt_q][3]);
		end
	end

endmodule

// ===== rtl/lav_norm.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Look-at view matrix: pipelined vector normalizer
// Scales a sign-magnitude 3-vector, takes the floor square root of its sum
// of squares one bit per stage, and divides each component by the length
// one quotient bit per stage, rounding halves away from zero.
// ---------------------------------------------------------------------------
module lav_norm (
	input  logic           clk,
	input  logic           en,
	input  logic [2:0]     neg,
	input  lav_pkg::mag_t  mag [3],
	output lav_pkg::unit_t unit [3],
	output logic           nz
);
	import lav_pkg::*;

	logic [MAG_W-1:0] mx;
	logic [LZ_W-1:0]  msb;
	logic [NRM_W-1:0] m_n [3];

	logic [NRM_W-1:0] m_s1 [3];
	logic [2:0]       neg_s1;
	logic             nz_s1;
	logic [SQ_W-1:0]  sq_s2 [3];
	logic [NRM_W-1:0] m_s2 [3];
	logic [2:0]       neg_s2;
	logic             nz_s2;

	logic [SUM_W-1:0]  rt_rem_s  [ROOT_W+1];
	logic [ROOT_W-1:0] rt_root_s [ROOT_W+1];
	logic [NRM_W-1:0]  rt_m_s    [ROOT_W+1][3];
	logic [2:0]        rt_neg_s  [ROOT_W+1];
	logic              rt_nz_s   [ROOT_W+1];

	logic [NUM_W-1:0]  dv_rem_s [QUO_W+1][3];
	logic [QUO_W-1:0]  dv_q_s   [QUO_W+1][3];
	logic [ROOT_W-1:0] dv_len_s [QUO_W+1];
	logic [2:0]        dv_neg_s [QUO_W+1];
	logic              dv_nz_s  [QUO_W+1];

	// Scale so that the largest magnitude has its top bit at NRM_W - 1.
	always_comb begin
		mx = mag[0];
		if (mag[1] > mx) mx = mag[1];
		if (mag[2] > mx) mx = mag[2];
		msb = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (mx[i]) msb = LZ_W'(i);
		end
		for (int i = 0; i < 3; i++) begin
			if (msb > LZ_W'(NRM_W - 1)) begin
				m_n[i] = NRM_W'(mag[i] >> (msb - LZ_W'(NRM_W - 1)));
			end else begin
				m_n[i] = NRM_W'(mag[i] << (LZ_W'(NRM_W - 1) - msb));
			end
		end
	end

	// Scale, square and sum stages.
	always_ff @(posedge clk) begin
		if (en) begin
			m_s1   <= m_n;
			neg_s1 <= neg;
			nz_s1  <= (mx != '0);
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= SQ_W'(m_s1[i]) * SQ_W'(m_s1[i]);
			end
			m_s2   <= m_s1;
			neg_s2 <= neg_s1;
			nz_s2  <= nz_s1;
			rt_rem_s[0]  <= SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);
			rt_root_s[0] <= '0;
			rt_m_s[0]    <= m_s2;
			rt_neg_s[0]  <= neg_s2;
			rt_nz_s[0]   <= nz_s2;
		end
	end

	// Square root: one root bit per stage, most significant first.
	for (genvar k = 0; k < ROOT_W; k++) begin : g_root
		localparam int J = ROOT_W - 1 - k;
		logic [SUM_W+1:0] trial;

		assign trial = ((SUM_W + 2)'(rt_root_s[k]) << (J + 1)) + ((SUM_W + 2)'(1) << (2 * J));

		always_ff @(posedge clk) begin
			if (en) begin
				if ({2'b00, rt_rem_s[k]} >= trial) begin
					rt_rem_s[k+1]  <= rt_rem_s[k] - SUM_W'(trial);
					rt_root_s[k+1] <= rt_root_s[k] | (ROOT_W'(1) << J);
				end else begin
					rt_rem_s[k+1]  <= rt_rem_s[k];
					rt_root_s[k+1] <= rt_root_s[k];
				end
				rt_m_s[k+1]   <= rt_m_s[k];
				rt_neg_s[k+1] <= rt_neg_s[k];
				rt_nz_s[k+1]  <= rt_nz_s[k];
			end
		end
	end

	// Dividend setup: component over length, plus half the length for rounding.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[0][i] <= (NUM_W'(rt_m_s[ROOT_W][i]) << FRAC_BITS)
					+ NUM_W'(rt_root_s[ROOT_W] >> 1);
				dv_q_s[0][i]   <= '0;
			end
			dv_len_s[0] <= rt_root_s[ROOT_W];
			dv_neg_s[0] <= rt_neg_s[ROOT_W];
			dv_nz_s[0]  <= rt_nz_s[ROOT_W];
		end
	end

	// Restoring division: one quotient bit per stage on all three lanes.
	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		localparam int B = QUO_W - 1 - k;
		logic [NUM_W:0] dsh;

		assign dsh = (NUM_W + 1)'(dv_len_s[k]) << B;

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if ({1'b0, dv_rem_s[k][i]} >= dsh) begin
						dv_rem_s[k+1][i] <= dv_rem_s[k][i] - NUM_W'(dsh);
						dv_q_s[k+1][i]   <= dv_q_s[k][i] | (QUO_W'(1) << B);
					end else begin
						dv_rem_s[k+1][i] <= dv_rem_s[k][i];
						dv_q_s[k+1][i]   <= dv_q_s[k][i];
					end
				end
				dv_len_s[k+1] <= dv_len_s[k];
				dv_neg_s[k+1] <= dv_neg_s[k];
				dv_nz_s[k+1]  <= dv_nz_s[k];
			end
		end
	end

	// Output register: apply the sign, zero a vector of zero length.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (!dv_nz_s[QUO_W]) begin
					unit[i] <= '0;
				end else if (dv_neg_s[QUO_W][i]) begin
					unit[i] <= -unit_t'(dv_q_s[QUO_W][i]);
				end else begin
					unit[i] <= unit_t'(dv_q_s[QUO_W][i]);
				end
			end
			nz <= dv_nz_s[QUO_W];
		end
	end

endmodule

// ===== sim/look_at_view_matrix_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Look-at view matrix unit testbench
// Drives eye, target and up words into the unit with random gaps, accepts the
// row words with random back-pressure, and checks every row against a local
// fixed-point model of the view matrix held in a small scoreboard.
// ---------------------------------------------------------------------------
module look_at_view_matrix_unit_tb;
	import lav_pkg::*;

	localparam int  N_RANDOM   = 390;
	localparam int  CYCLE_LIMIT = 600000;
	localparam int  DRAIN_CYCLES = 300;
	localparam int  FB = FRAC_BITS;

	typedef struct {
		fx_t eye[3];
		fx_t tgt[3];
		fx_t up[3];
	} view_in_t;

	typedef struct {
		logic [1:0] idx;
		fx_t        e[4];
		logic       deg;
		logic       last;
	} row_t;

	// Saturate a wide signed value to the data range.
	function automatic fx_t sat_fx(input logic signed [127:0] v);
		logic signed [127:0] hi;
		logic signed [127:0] lo;
		hi = (128'sd1 <<< (DATA_WIDTH - 1)) - 1;
		lo = -(128'sd1 <<< (DATA_WIDTH - 1));
		if (v > hi)
			return fx_t'(hi);
		if (v < lo)
			return fx_t'(lo);
		return fx_t'(v);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Sign plus magnitude vector to unit length; returns 0 for a zero vector.
	function automatic bit unit_vec(input bit neg[3], input longint unsigned mag[3],
			output longint o[3]);
		longint unsigned m[3];
		longint unsigned mx;
		longint unsigned sum;
		longint unsigned len;
		longint unsigned q;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = mag[i];
			if (m[i] > mx)
				mx = m[i];
			o[i] = 0;
		end
		if (mx == 0)
			return 0;
		while (mx >= (64'd1 << 31)) begin
			for (int i = 0; i < 3; i++)
				m[i] = m[i] >> 1;
			mx = mx >> 1;
		end
		while (mx < (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++)
				m[i] = m[i] << 1;
			mx = mx << 1;
		end
		sum = 0;
		for (int i = 0; i < 3; i++)
			sum = sum + m[i] * m[i];
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << FB) + len / 2) / len;
			o[i] = neg[i] ? -longint'(q) : longint'(q);
		end
		return 1;
	endfunction

	function automatic longint abs64(input longint v);
		return v < 0 ? -v : v;
	endfunction

	// Round a double-precision fraction back to FB bits, halves away from zero.
	function automatic longint round_frac(input longint v);
		longint unsigned m;
		m = (longint'(abs64(v)) + (64'd1 << (FB - 1))) >> FB;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	// Row dot product with -eye, rounded to FB bits and saturated.
	function automatic fx_t translate(input longint r[3], input longint eye[3]);
		logic signed [127:0] acc;
		logic signed [127:0] v;
		logic signed [127:0] mg;
		logic signed [127:0] val;
		acc = 0;
		for (int i = 0; i < 3; i++)
			acc = acc + 128'(signed'(r[i])) * 128'(signed'(eye[i]));
		v = -acc;
		mg = v < 0 ? -v : v;
		mg = (mg + (128'sd1 <<< (FB - 1))) >>> FB;
		val = v < 0 ? -mg : mg;
		return sat_fx(val);
	endfunction

	class view_scoreboard;
		row_t pending[$];
		int   errors;

		function new();
			errors = 0;
		endfunction

		// Work out the four rows that one accepted point word produces.
		function void note(view_in_t p);
			longint eye[3], f[3], un[3], sr[3], ns[3], uw[3];
			longint rw[3][3];
			longint unsigned mf[3], mu[3], ms[3];
			bit nf[3], nu[3], nsg[3];
			bit ok, ok_up;
			longint t, u;
			row_t r;
			for (int i = 0; i < 3; i++) begin
				eye[i] = longint'(p.eye[i]);
				t = longint'(p.tgt[i]);
				u = longint'(p.up[i]);
				nf[i] = t < eye[i];
				mf[i] = abs64(t - eye[i]);
				nu[i] = u < 0;
				mu[i] = abs64(u);
				for (int j = 0; j < 3; j++)
					rw[i][j] = 0;
			end
			ok = unit_vec(nf, mf, f);
			ok_up = unit_vec(nu, mu, un);
			ok = ok && ok_up;
			if (ok) begin
				sr[0] = f[1] * un[2] - f[2] * un[1];
				sr[1] = f[2] * un[0] - f[0] * un[2];
				sr[2] = f[0] * un[1] - f[1] * un[0];
				for (int i = 0; i < 3; i++) begin
					nsg[i] = sr[i] < 0;
					ms[i] = abs64(sr[i]);
				end
				ok = unit_vec(nsg, ms, ns);
			end
			if (ok) begin
				uw[0] = ns[1] * f[2] - ns[2] * f[1];
				uw[1] = ns[2] * f[0] - ns[0] * f[2];
				uw[2] = ns[0] * f[1] - ns[1] * f[0];
				for (int i = 0; i < 3; i++) begin
					rw[0][i] = ns[i];
					rw[1][i] = round_frac(uw[i]);
					rw[2][i] = -f[i];
				end
			end
			for (int k = 0; k < 3; k++) begin
				r.idx = 2'(k);
				for (int i = 0; i < 3; i++)
					r.e[i] = sat_fx(128'(signed'(rw[k][i])));
				r.e[3] = ok ? translate(rw[k], eye) : fx_t'(0);
				r.deg = !ok;
				r.last = 1'b0;
				pending.push_back(r);
			end
			r.idx = LAST_ROW;
			r.e[0] = 0;
			r.e[1] = 0;
			r.e[2] = 0;
			r.e[3] = sat_fx(128'sd1 <<< FB);
			r.deg = !ok;
			r.last = 1'b1;
			pending.push_back(r);
		endfunction

		// Compare one row word with the oldest expected row.
		function void check(row_t got);
			row_t x;
			if (pending.size() == 0) begin
				$error("row word with nothing expected: row_index %0d", got.idx);
				errors++;
				return;
			end
			x = pending.pop_front();
			if (got.idx !== x.idx) begin
				$error("row_index: expected %0d, got %0d", x.idx, got.idx);
				errors++;
			end
			for (int i = 0; i < 4; i++)
				if (got.e[i] !== x.e[i]) begin
					$error("entry_%0d (row %0d): expected %0d, got %0d",
						i, x.idx, x.e[i], got.e[i]);
					errors++;
				end
			if (got.deg !== x.deg) begin
				$error("degenerate: expected %0d, got %0d", x.deg, got.deg);
				errors++;
			end
			if (got.last !== x.last) begin
				$error("last_row: expected %0d, got %0d", x.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycle = 0;
	view_scoreboard sb;

	lav_pts_if  pts_ch();
	lav_rows_if rows_ch();

	look_at_view_matrix_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pts    (pts_ch.sink),
		.rows   (rows_ch.source)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CYCLE_LIMIT) begin
			$display("look_at_view_matrix_unit_tb NOT OK");
			$finish;
		end
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 60);
		return $urandom_range(0, 2);
	endfunction

	// Offer one point word and wait until it is taken.
	task automatic send_pt(input view_in_t p, input int gap);
		if (gap > 0) begin
			pts_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pts_ch.valid    <= 1'b1;
		pts_ch.eye_x    <= p.eye[0];
		pts_ch.eye_y    <= p.eye[1];
		pts_ch.eye_z    <= p.eye[2];
		pts_ch.target_x <= p.tgt[0];
		pts_ch.target_y <= p.tgt[1];
		pts_ch.target_z <= p.tgt[2];
		pts_ch.up_x     <= p.up[0];
		pts_ch.up_y     <= p.up[1];
		pts_ch.up_z     <= p.up[2];
		@(posedge clk);
		while (!(pts_ch.valid && pts_ch.ready))
			@(posedge clk);
		sb.note(p);
	endtask

	function automatic fx_t rand_coord(input int kind);
		case (kind)
			0: return fx_t'($urandom);
			1: return fx_t'(int'($urandom_range(0, 2097152)) - 1048576);
			default: return fx_t'(int'($urandom_range(0, 16)) - 8);
		endcase
	endfunction

	function automatic view_in_t mk(input fx_t e0, e1, e2, t0, t1, t2, u0, u1, u2);
		view_in_t p;
		p.eye = '{e0, e1, e2};
		p.tgt = '{t0, t1, t2};
		p.up  = '{u0, u1, u2};
		return p;
	endfunction

	// Well-formed views mostly, with degenerate and full-range words mixed in.
	function automatic view_in_t rand_view();
		view_in_t p;
		int kind;
		int sel;
		sel = $urandom_range(0, 99);
		kind = sel < 20 ? 0 : (sel < 85 ? 1 : 2);
		for (int i = 0; i < 3; i++) begin
			p.eye[i] = rand_coord(kind);
			p.tgt[i] = rand_coord(kind);
			p.up[i]  = rand_coord($urandom_range(0, 2));
		end
		sel = $urandom_range(0, 19);
		if (sel == 0)
			p.tgt = p.eye;
		else if (sel == 1)
			p.up = '{0, 0, 0};
		else if (sel == 2 && kind != 0)
			for (int i = 0; i < 3; i++)
				p.up[i] = p.tgt[i] - p.eye[i];
		return p;
	endfunction

	localparam fx_t MAXV = fx_t'({1'b0, {(DATA_WIDTH-1){1'b1}}});
	localparam fx_t MINV = fx_t'({1'b1, {(DATA_WIDTH-1){1'b0}}});
	localparam fx_t ONE  = ONE_FX;

	// Stimulus.
	initial begin
		view_in_t dir[$];
		sb = new();
		arst_n = 1'b0;
		pts_ch.valid <= 1'b0;
		pts_ch.eye_x <= '0;
		pts_ch.eye_y <= '0;
		pts_ch.eye_z <= '0;
		pts_ch.target_x <= '0;
		pts_ch.target_y <= '0;
		pts_ch.target_z <= '0;
		pts_ch.up_x <= '0;
		pts_ch.up_y <= '0;
		pts_ch.up_z <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed views: plain camera, extremes, and the degenerate cases.
		dir.push_back(mk(0, 0, 5*ONE, 0, 0, 0, 0, ONE, 0));
		dir.push_back(mk(ONE, 2*ONE, 3*ONE, -ONE, 0, 7*ONE, 0, 0, ONE));
		dir.push_back(mk(MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV, MINV, 0));
		dir.push_back(mk(MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV, MAXV, MAXV));
		dir.push_back(mk(MINV, 0, MAXV, MAXV, 0, MINV, 0, MAXV, 0));
		dir.push_back(mk(MAXV, MINV, 0, 0, MAXV, MINV, 1, 1, 1));
		dir.push_back(mk(0, 0, 0, 1, 0, 0, 0, 1, 0));
		dir.push_back(mk(0, 0, 0, 0, 0, -1, MINV, MINV, MINV));
		dir.push_back(mk(3*ONE, 3*ONE, 3*ONE, 3*ONE, 3*ONE, 3*ONE, 0, ONE, 0));
		dir.push_back(mk(MINV, MINV, MINV, MINV, MINV, MINV, ONE, 0, 0));
		dir.push_back(mk(0, 0, 0, ONE, 0, 0, 0, 0, 0));
		dir.push_back(mk(0, 0, 0, ONE, ONE, 0, 2*ONE, 2*ONE, 0));
		dir.push_back(mk(0, 0, 0, 0, ONE, 0, 0, -5, 0));
		dir.push_back(mk(0, 0, 0, MAXV, 1, 0, 1, 0, 0));
		dir.push_back(mk(-1, -1, -1, 1, 1, 1, -1, 1, -1));
		dir.push_back(mk(MAXV, MAXV, MAXV, 0, 0, 0, MAXV, MAXV, MINV));
		dir.push_back(mk(MINV, MAXV, MINV, MAXV, MINV, MAXV, 1, MINV, 1));
		dir.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1));
		dir.push_back(mk(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
		dir.push_back(mk(0, 0, 0, 0, 0, ONE, 0, ONE, 1));
		foreach (dir[k])
			send_pt(dir[k], $urandom_range(0, 1) ? 0 : pick_gap());

		// Random views; bursts without gaps alternate with gappy stretches.
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 2) begin
				// Let the unit drain completely before going on.
				pts_ch.valid <= 1'b0;
				while (sb.pending.size() != 0)
					@(posedge clk);
				@(posedge clk);
			end
			send_pt(rand_view(), ((n / 40) % 2 == 0) ? 0 : pick_gap());
		end
		pts_ch.valid <= 1'b0;

		// Drain.
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("look_at_view_matrix_unit_tb OK");
		end else begin
			$display("look_at_view_matrix_unit_tb NOT OK");
		end
		$finish;
	end

	// Row receiver with random back-pressure and one long hold-off.
	initial begin
		int hold;
		int rx_cycles;
		row_t got;
		hold = 0;
		rx_cycles = 0;
		rows_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				rx_cycles++;
				if (rows_ch.valid && rows_ch.ready) begin
					got.idx  = rows_ch.row_index;
					got.e[0] = rows_ch.entry_0;
					got.e[1] = rows_ch.entry_1;
					got.e[2] = rows_ch.entry_2;
					got.e[3] = rows_ch.entry_3;
					got.deg  = rows_ch.degenerate;
					got.last = rows_ch.last_row;
					sb.check(got);
				end
				if (rx_cycles == 600)
					hold = 900;
				else if (hold == 0 && $urandom_range(0, 149) == 0)
					hold = $urandom_range(15, 70);
				if (hold > 0) begin
					hold--;
					rows_ch.ready <= 1'b0;
				end else if ((rx_cycles / 500) % 3 == 1) begin
					rows_ch.ready <= 1'b1;
				end else begin
					rows_ch.ready <= ($urandom_range(0, 3) != 0);
				end
			end
		end
	end

endmodule
